// ===== hdl/rset_pkg.sv =====
// ----------------------------------------------------------------------------
// Randomized set table package
// Shared widths, operation and status codes, and the command word passed
// from the front end to the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rset_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths fixed by the interface.
  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 7;

  // Depth of the command queue between front end and engine.
  localparam int FIFO_DEPTH = 2;

  // Operation codes as they arrive on the input channel.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd4;

  // Decoded command class.
  typedef enum logic [1:0] {
    K_INSERT,
    K_REMOVE,
    K_PICK,
    K_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [DATA_W-1:0]  value;
    logic        [DATA_W-1:0]  random_word;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rset_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rset_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rset_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rset_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rset_pkg::cmd_t     data_o
);
  import rset_pkg::*;

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  cmd_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) r = '0;
    else                             r = p + 1'b1;
    return r;
  endfunction

  assign full_o  = (fill_q == FILL_W'(FIFO_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop)      fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rset_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts input words, decodes the operation code and hands commands to the
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rset_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rset_pkg::OP_W-1:0]     operation_i,
  input  wire logic signed [rset_pkg::DATA_W-1:0] value_i,
  input  wire logic [rset_pkg::DATA_W-1:0]   random_word_i,
  output logic                               push_o,
  output rset_pkg::cmd_t                     push_data_o,
  input  wire logic                          full_i
);
  import rset_pkg::*;

  logic vld_q;
  cmd_t cmd_q;
  cmd_t cmd_d;
  logic accept;

  always_comb begin
    cmd_d.value       = value_i;
    cmd_d.random_word = random_word_i;
    case (operation_i)
      OP_INSERT: cmd_d.kind = K_INSERT;
      OP_REMOVE: cmd_d.kind = K_REMOVE;
      OP_PICK:   cmd_d.kind = K_PICK;
      default:   cmd_d.kind = K_NOP;
    endcase
  end

  assign in_stall_o  = vld_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = vld_q && !full_i;
  assign push_data_o = cmd_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rset_engine.sv =====
// ----------------------------------------------------------------------------
// Execution engine
// Runs one command at a time against the element RAM: linear search,
// append, swap-with-last removal and indexed pick, then the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rset_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire rset_pkg::cmd_t               cmd_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              success_o,
  output logic [rset_pkg::STAT_W-1:0]       status_o,
  output logic signed [rset_pkg::DATA_W-1:0] picked_o,
  output logic [rset_pkg::OCC_W-1:0]        occupancy_o
);
  import rset_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_REM_RD,
    S_REM_WR,
    S_PICK_RD,
    S_PICK_WAIT,
    S_FINISH
  } state_e;

  localparam int PROD_W = DATA_W + CNT_W;

  state_e             state_q;
  cmd_kind_e          kind_q;
  logic [DATA_W-1:0]  val_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   issue_q;
  logic               chk_vld_q;
  logic [IDX_W-1:0]   chk_idx_q;
  logic [IDX_W-1:0]   pos_q;
  logic [IDX_W-1:0]   idx_q;

  logic               res_success_q;
  logic [STAT_W-1:0]  res_status_q;
  logic [DATA_W-1:0]  res_picked_q;

  logic               out_vld_q;
  logic               out_success_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [DATA_W-1:0]  out_picked_q;
  logic [OCC_W-1:0]   out_occ_q;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [DATA_W-1:0]  wr_data, rd_data;
  logic               hit, miss, room;
  logic [CNT_W-1:0]   last;
  logic [PROD_W-1:0]  prod;
  logic               out_load;

  rset_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign last = count_q - 1'b1;
  assign room = (count_q < CNT_W'(CAPACITY));
  assign prod = PROD_W'(cmd_i.random_word) * PROD_W'(count_q);
  assign hit  = (state_q == S_SEARCH) && chk_vld_q && (rd_data == val_q);
  assign miss = (state_q == S_SEARCH) && !hit && !chk_vld_q && (issue_q >= count_q);

  // The result moves into the output register when that register is free or
  // is being emptied at this edge.
  assign out_load = (state_q == S_FINISH) && (!out_vld_q || !out_stall_i);

  // RAM port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_q[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = val_q;
    pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        pop_o = cmd_valid_i;
      end
      S_SEARCH: begin
        rd_en = !hit && (issue_q < count_q);
        if (miss && (kind_q == K_INSERT) && room) begin
          wr_en = 1'b1;
        end
      end
      S_REM_RD: begin
        rd_en   = 1'b1;
        rd_addr = last[IDX_W-1:0];
      end
      S_REM_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = rd_data;
      end
      S_PICK_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        kind_q       <= cmd_i.kind;
        val_q        <= cmd_i.value;
        idx_q        <= prod[DATA_W +: IDX_W];
        res_picked_q <= '0;
      end
      S_SEARCH: begin
        chk_idx_q <= issue_q[IDX_W-1:0];
        if (hit) pos_q <= chk_idx_q;
      end
      S_PICK_WAIT: begin
        res_picked_q <= rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      issue_q       <= '0;
      chk_vld_q     <= 1'b0;
      res_success_q <= 1'b0;
      res_status_q  <= ST_OK;
      out_vld_q     <= 1'b0;
      out_success_q <= 1'b0;
      out_status_q  <= ST_OK;
      out_picked_q  <= '0;
      out_occ_q     <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          issue_q   <= '0;
          chk_vld_q <= 1'b0;
          if (cmd_valid_i) begin
            res_success_q <= 1'b0;
            res_status_q  <= ST_OK;
            case (cmd_i.kind)
              K_INSERT, K_REMOVE: state_q <= S_SEARCH;
              K_PICK: begin
                if (count_q == '0) begin
                  res_status_q <= ST_EMPTY;
                  state_q      <= S_FINISH;
                end else begin
                  state_q <= S_PICK_RD;
                end
              end
              default: state_q <= S_FINISH;
            endcase
          end
        end
        S_SEARCH: begin
          chk_vld_q <= rd_en;
          if (rd_en) issue_q <= issue_q + 1'b1;
          if (hit) begin
            if (kind_q == K_INSERT) begin
              res_status_q <= ST_PRESENT;
              state_q      <= S_FINISH;
            end else begin
              state_q <= S_REM_RD;
            end
          end else if (miss) begin
            state_q <= S_FINISH;
            if (kind_q == K_INSERT) begin
              if (room) begin
                count_q       <= count_q + 1'b1;
                res_success_q <= 1'b1;
              end else begin
                res_status_q <= ST_FULL;
              end
            end else begin
              res_status_q <= ST_NOT_PRESENT;
            end
          end
        end
        S_REM_RD: state_q <= S_REM_WR;
        S_REM_WR: begin
          count_q       <= last;
          res_success_q <= 1'b1;
          state_q       <= S_FINISH;
        end
        S_PICK_RD: state_q <= S_PICK_WAIT;
        S_PICK_WAIT: begin
          res_success_q <= 1'b1;
          state_q       <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_success_q <= res_success_q;
            out_status_q  <= res_status_q;
            out_picked_q  <= res_picked_q;
            out_occ_q     <= OCC_W'(count_q);
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign success_o   = out_success_q;
  assign status_o    = out_status_q;
  assign picked_o    = out_picked_q;
  assign occupancy_o = out_occ_q;

`ifndef SYNTH
  // The live count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // The count moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
         count_q == $past(count_q) - 1'b1))
    else $error("element count jumped");

  // A successful result always carries the ok status.
  a_success_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_success_q |-> out_status_q == ST_OK)
    else $error("success with error status");

  // A failed result never carries a picked element.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_success_q |-> out_picked_q == '0)
    else $error("picked element on failed word");
`endif

endmodule

`default_nettype wire

// ===== hdl/randomized_set_table.sv =====
// ----------------------------------------------------------------------------
// Randomized set table
// Set of distinct 32-bit values with insert, remove and uniform pick.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Word fields
//   --------+-----------+-------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o | operation, value, random_word
//   out     | output    | out_valid_o/ out_stall_i| success, status, picked, occupancy
//
// A search reads the live entries one per cycle through the single RAM read
// port and stops at a hit; a remove then swaps the last entry into the freed
// slot. The worst case is a remove of the last of 64 entries. Reset clears
// the count and all control; the element RAM is not cleared. Out stall holds
// the output register while the front end and the queue keep taking input
// words until both of them are full.
//
// The design is split into a front end that registers and decodes each input
// word, a two-entry command queue, and an engine that owns the element RAM
// and the output register. Membership is decided by a linear search over the
// live entries; removal copies the last live entry into the freed slot; pick
// uses index = (random_word * count) >> 32, which is always below count.
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_set_table (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [rset_pkg::OP_W-1:0]          operation_i,
  input  wire logic signed [rset_pkg::DATA_W-1:0] value_i,
  input  wire logic [rset_pkg::DATA_W-1:0]        random_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    success_o,
  output logic [rset_pkg::STAT_W-1:0]             status_o,
  output logic signed [rset_pkg::DATA_W-1:0]      picked_o,
  output logic [rset_pkg::OCC_W-1:0]              occupancy_o
);
  import rset_pkg::*;

  // Front end to queue.
  logic push;
  cmd_t push_data;
  logic full;

  // Queue to engine.
  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  rset_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .random_word_i (random_word_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  rset_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .data_o      (cmd)
  );

  // The engine executes commands in order and owns the output register.
  rset_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .success_o   (success_o),
    .status_o    (status_o),
    .picked_o    (picked_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_randomized_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Randomized set table testbench
// Drives insert, remove, pick and unused operation words into the set table
// with random bursts and gaps on the input side and random stall patterns on
// the output side. A shadow copy of the dense element array and its count
// predicts every result word, and each result is compared field by field
// with the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb_randomized_set_table;

  import rset_pkg::*;

  // The fourth operation code is not used by the block. It is still sent so
  // that the default decode of the operation field is exercised.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The worst case per word comes with a full table, plus input gaps and
  // output stalls. This limit is several times that worst case for about
  // 960 words.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 100;
  localparam int MAX_REPORTS  = 10;

  // One result word as the block presents it.
  typedef struct packed {
    logic                     success;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] picked;
    logic [OCC_W-1:0]         occupancy;
  } set_result_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          operation_i   = OP_INSERT;
  logic signed [DATA_W-1:0] value_i       = '0;
  logic [DATA_W-1:0]        random_word_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic                     success_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] picked_o;
  logic [OCC_W-1:0]         occupancy_o;

  // Shadow of the table contents: live entries sit below shadow_count, in the
  // same order as in the block, since remove moves the last entry into the
  // freed slot in both.
  logic [DATA_W-1:0] shadow_elems [CAPACITY];
  int                shadow_count = 0;

  // Predicted result words, oldest first.
  set_result_t pending_results [$];

  int fail_count  = 0;
  int cycle_count = 0;

  // Words left in the current input burst. Zero means a new burst starts,
  // possibly after a gap.
  int burst_left = 0;

  // Output stall pattern state.
  int stall_mode     = 0;
  int stall_seg_left = 0;

  randomized_set_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .random_word_i (random_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .success_o     (success_o),
    .status_o      (status_o),
    .picked_o      (picked_o),
    .occupancy_o   (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one operation to the shadow table and returns the result word the
  // block must produce for it. Membership is decided before fullness, so a
  // duplicate insert into a full table reports the value as present.
  function automatic set_result_t apply_set_op(input logic [OP_W-1:0]   op,
                                               input logic [DATA_W-1:0] val,
                                               input logic [DATA_W-1:0] rword);
    set_result_t      r;
    int               pos;
    logic [63:0]      scaled;
    logic [IDX_W-1:0] pick_idx;
    r   = '0;
    pos = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_elems[i] == val) begin
        pos = i;
      end
    end
    case (op)
      OP_INSERT: begin
        if (pos >= 0) begin
          r.status = ST_PRESENT;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_elems[shadow_count] = val;
          shadow_count++;
          r.success = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOT_PRESENT;
        end else begin
          shadow_elems[pos] = shadow_elems[shadow_count - 1];
          shadow_count--;
          r.success = 1'b1;
        end
      end
      OP_PICK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // The scaled index is always below the count, so no clamp is needed.
          scaled    = 64'(rword) * 64'(shadow_count);
          pick_idx  = scaled[32 +: IDX_W];
          r.picked  = shadow_elems[pick_idx];
          r.success = 1'b1;
        end
      end
      default: begin
        // Unused code: the block ignores the word apart from reporting the
        // current occupancy.
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // A value that is live in the table right now, for duplicate inserts and
  // successful removes. Only meaningful while the table is not empty.
  function automatic logic [DATA_W-1:0] live_value();
    return shadow_elems[$urandom_range(0, shadow_count - 1)];
  endfunction

  // A value for a fresh insert. Half of them come from a narrow band around
  // zero so that duplicates and misses happen often; the rest span all bits.
  function automatic logic [DATA_W-1:0] fresh_value();
    if ($urandom_range(0, 1) == 0) begin
      return DATA_W'($signed($urandom_range(0, 31)) - 16);
    end
    return $urandom();
  endfunction

  // Random word for pick, with the two ends of the range thrown in.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // True when the value is live in the shadow table.
  function automatic bit apply_probe(input logic [DATA_W-1:0] val);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_elems[i] == val) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Sends one word and records its prediction once the block has taken it.
  // Valid stays high across back-to-back words of a burst; it is lowered only
  // when a gap follows, so each edge carries a single update of it.
  task automatic send_word(input logic [OP_W-1:0]   op,
                           input logic [DATA_W-1:0] val,
                           input logic [DATA_W-1:0] rword);
    int          gap;
    set_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    value_i       <= val;
    random_word_i <= rword;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predicted       = apply_set_op(op, val, rword);
    pending_results = {pending_results, predicted};
  endtask

  // Holds the input idle until every predicted word has come back. At least
  // one edge passes with valid low, so the next word starts on a later edge.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk_i);
    end while (pending_results.size() != 0);
  endtask

  // Operations on an empty table: every one of them must fail cleanly.
  task automatic test_empty_table();
    send_word(OP_PICK, $urandom(), $urandom());
    send_word(OP_REMOVE, '0, $urandom());
    send_word(OP_UNUSED, $urandom(), $urandom());
  endtask

  // Extreme values, duplicates, picks at both ends of the random word, the
  // swap on removal of an inner entry and a remove of a value already gone.
  task automatic test_extreme_values();
    send_word(OP_INSERT, 32'h8000_0000, '0);
    send_word(OP_INSERT, 32'h7fff_ffff, '1);
    send_word(OP_INSERT, 32'h0000_0000, $urandom());
    send_word(OP_INSERT, 32'hffff_ffff, $urandom());
    send_word(OP_INSERT, 32'h0000_0001, $urandom());
    send_word(OP_INSERT, 32'h8000_0000, $urandom());
    send_word(OP_PICK, $urandom(), '0);
    send_word(OP_PICK, $urandom(), '1);
    send_word(OP_PICK, $urandom(), 32'h8000_0000);
    // Zero sits in the middle, so removing it pulls the last entry forward.
    send_word(OP_REMOVE, 32'h0000_0000, $urandom());
    send_word(OP_PICK, $urandom(), 32'h9999_9999);
    send_word(OP_REMOVE, 32'h0000_0000, $urandom());
    send_word(OP_REMOVE, 32'h7fff_ffff, $urandom());
    send_word(OP_UNUSED, 32'hffff_ffff, '1);
    send_word(OP_PICK, '1, $urandom());
  endtask

  // Fills the table to capacity, then checks the full case, the ordering of
  // the membership check before the fullness check, and picks over a full
  // table. The sender first waits for every result so that the table state
  // is settled when the phase begins.
  task automatic test_full_table();
    logic [DATA_W-1:0] val;
    wait_for_results();
    while (shadow_count < CAPACITY) begin
      send_word(OP_INSERT, $urandom(), $urandom());
    end
    do begin
      val = $urandom();
    end while (apply_probe(val));
    send_word(OP_INSERT, val, $urandom());
    send_word(OP_INSERT, live_value(), $urandom());
    send_word(OP_PICK, $urandom(), '0);
    send_word(OP_PICK, $urandom(), '1);
    send_word(OP_REMOVE, shadow_elems[CAPACITY - 1], $urandom());
    send_word(OP_REMOVE, shadow_elems[0], $urandom());
    send_word(OP_INSERT, val, $urandom());
    send_word(OP_INSERT, fresh_value(), $urandom());
    send_word(OP_INSERT, $urandom(), $urandom());
  endtask

  // Random traffic in phases that lean toward filling, draining or a balance,
  // so that the count sweeps between empty and full many times. Most words
  // are meaningful operations on live or fresh values; a few are misses and
  // unused codes.
  task automatic test_random_traffic(input int word_total);
    int                phase;
    int                roll;
    int                insert_cut;
    int                remove_cut;
    logic [DATA_W-1:0] val;
    phase = 2;
    for (int n = 0; n < word_total; n++) begin
      if (n % 120 == 0) begin
        phase = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 1) begin
          wait_for_results();
        end
      end
      case (phase)
        0:       begin insert_cut = 65; remove_cut = 80; end
        1:       begin insert_cut = 20; remove_cut = 80; end
        default: begin insert_cut = 40; remove_cut = 75; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < insert_cut) begin
        if (shadow_count > 0 && $urandom_range(0, 4) == 0) begin
          val = live_value();
        end else begin
          val = fresh_value();
        end
        send_word(OP_INSERT, val, $urandom());
      end else if (roll < remove_cut) begin
        if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
          val = live_value();
        end else begin
          val = fresh_value();
        end
        send_word(OP_REMOVE, val, $urandom());
      end else if (roll < 96) begin
        send_word(OP_PICK, $urandom(), pick_word());
      end else begin
        send_word(OP_UNUSED, $urandom(), $urandom());
      end
    end
  endtask

  // Output stall pattern: segments of a random mode, from never stalling
  // through light and heavy random stalls to a regular rhythm, so that stalls
  // land on every phase of the engine's search.
  always @(posedge clk_i) begin
    if (stall_seg_left == 0) begin
      stall_mode     = $urandom_range(0, 3);
      stall_seg_left = $urandom_range(20, 200);
    end else begin
      stall_seg_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 9) < 3);
      2:       out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= (cycle_count % 7 < 2);
    endcase
  end

  // Result checker. Each accepted result word is matched against the oldest
  // prediction; a word with nothing pending is a failure of its own.
  always @(posedge clk_i) begin : check_results
    set_result_t got;
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{success_o, status_o, picked_o, occupancy_o};
      if (pending_results.size() == 0) begin
        note_failure($sformatf({"result word with nothing expected: success=%0b status=%0d ",
                                "picked=%h occupancy=%0d"},
                               got.success, got.status, got.picked, got.occupancy));
      end else begin
        want = pending_results.pop_front();
        if (got.success !== want.success || got.status !== want.status ||
            got.picked !== want.picked || got.occupancy !== want.occupancy) begin
          note_failure($sformatf({"mismatch: expected success=%0b status=%0d picked=%h ",
                                  "occupancy=%0d, got success=%0b status=%0d picked=%h ",
                                  "occupancy=%0d"},
                                 want.success, want.status, want.picked, want.occupancy,
                                 got.success, got.status, got.picked, got.occupancy));
        end
      end
    end
  end

  // Watchdog for a block that hangs or drops words.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Reset is held low from time zero and released on a clock edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_extreme_values();
    test_full_table();
    test_random_traffic(870);

    // Let every pending word come back, then give the block time to show any
    // stray result before the verdict.
    wait_for_results();
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
